// ===== design/sdt_pkg.sv =====
package sdt_pkg;

    // defaults for the top level parameters
    localparam int KEYWORD_BYTES_DEF = 16;   // range 14 to 32
    localparam int OFFSET_BITS_DEF   = 16;   // range 8 to 32

    // output field widths
    localparam int KIND_W = 6;
    localparam int FIELD_W = 16;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_ID    = 6'd0;
    localparam logic [KIND_W-1:0] KIND_DOT   = 6'd1;
    localparam logic [KIND_W-1:0] KIND_COMMA = 6'd2;
    localparam logic [KIND_W-1:0] KIND_LP    = 6'd3;
    localparam logic [KIND_W-1:0] KIND_RP    = 6'd4;
    localparam logic [KIND_W-1:0] KIND_EQ    = 6'd5;
    localparam logic [KIND_W-1:0] KIND_KW0   = 6'd6;
    localparam logic [KIND_W-1:0] KIND_END   = 6'd54;

    // byte codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_BQUOTE  = 8'h60;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // keyword table, text right-justified and zero-padded
    localparam int KW_COUNT   = 48;
    localparam int KW_MAX_LEN = 14;
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "ADD", "AFTER", "ALTER", {"AUTO_", "INCREMENT"}, "CASCADE", "CHANGE",
        {"COLUMN_", "FORMAT"}, "COLUMN", "COMMENT", "CONSTRAINT", "CREATE", "DEFAULT",
        "DROP", "DYNAMIC", "EXISTS", "FIRST", "FIXED", "FOREIGN", "FULLTEXT",
        "IF", "IGNORE", "INDEX", "INVISIBLE", "KEY", "KEYS", "LIKE", "MODIFY",
        "NOT", "ONLINE", "OR", "PERIOD", "PRIMARY", {"REF_", "SYSTEM_ID"}, "REMOVE",
        "RENAME", "REPLACE", "RESTRICT", "SPATIAL", "SYSTEM", "TABLE", "TO",
        "UNIQUE", "UNSIGNED", "VERSIONING", "WITH", "WITHOUT", "ZEROFILL", "NULL"
    };

    // result queue depth, room for two tokens per byte plus slack
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WORD  = 2'd1,
        MODE_QUOTE = 2'd2,
        MODE_ESC   = 2'd3
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               unterminated;
        logic               last;
    } token_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic ends_word(input logic [7:0] c);
        return (c == CH_DOT) || (c == CH_COMMA) || (c == CH_LPAREN) ||
               (c == CH_RPAREN) || (c == CH_BQUOTE) || (c == CH_SQUOTE) ||
               (c == CH_DQUOTE) || (c == CH_EQUALS) || is_space(c);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? (c - CASE_DIFF) : c;
    endfunction

    // number of text bytes in keyword i
    function automatic int kw_len(input int i);
        logic [KW_MAX_LEN*8-1:0] t;
        int n;
        t = KW_TEXT[i];
        n = 0;
        for (int j = 0; j < KW_MAX_LEN; j++) begin
            if (t[8*j +: 8] != CH_NUL) begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    // byte j of keyword i, counted from the first character
    function automatic logic [7:0] kw_byte(input int i, input int j);
        logic [KW_MAX_LEN*8-1:0] t;
        int n;
        logic [7:0] b;
        t = KW_TEXT[i];
        n = kw_len(i);
        b = CH_NUL;
        if (j < n) begin
            b = t[8*(n-1-j) +: 8];
        end
        return b;
    endfunction

endpackage

// ===== design/sdt_kw_match.sv =====
module sdt_kw_match #(
    parameter int KEYWORD_BYTES = 16,
    parameter int CNT_W = 5
) (
    input  logic [KEYWORD_BYTES*8-1:0] word_bytes,
    input  logic [CNT_W-1:0]           word_count,
    input  logic                       word_overlong,
    output logic [5:0]                 kind
);
    import sdt_pkg::*;

    logic hit;

    // parallel compare against every keyword, first table entry wins
    always_comb
    begin
        kind = KIND_ID;
        hit = 1'b0;
        for (int i = KW_COUNT - 1; i >= 0; i--)
        begin
            hit = !word_overlong && (int'(word_count) == kw_len(i));
            for (int j = 0; j < KW_MAX_LEN; j++)
            begin
                if ((j < kw_len(i)) && (word_bytes[8*j +: 8] != kw_byte(i, j)))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kind = KIND_KW0 + KIND_W'(i);
            end
        end
    end

endmodule

// ===== design/sdt_tok_fifo.sv =====
module sdt_tok_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  sdt_pkg::token_t  push0,
    input  sdt_pkg::token_t  push1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output sdt_pkg::token_t  out_tok
);
    import sdt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic               pop;

    // status toward both sides
    assign out_valid = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_tok   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_plus1 = PTR_W'(wr_ptr_reg + 1'b1);
        wr_ptr_next  = PTR_W'(wr_ptr_reg + PTR_W'(push_cnt));
        rd_ptr_next  = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next   = CNT_W'(count_reg + CNT_W'(push_cnt) - CNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("token queue occupancy beyond depth");

endmodule

// ===== design/sql_ddl_tokenizer_unit.sv =====
// Output: a token enters the token queue when the byte that completes it is accepted and
// is offered from there in order; a zero byte yields any pending word and then the end token.
// Throughput: one byte per cycle while the queue has room; a punctuation byte that closes
// a word makes two tokens, and the four-entry token queue then throttles input to the drain rate.
// Reset: rst_n clears the scanner to idle between tokens with offset zero and empties
// the queue; the same clean state returns after every end token.
module sql_ddl_tokenizer_unit #(
    parameter int KEYWORD_BYTES = sdt_pkg::KEYWORD_BYTES_DEF,
    parameter int OFFSET_BITS   = sdt_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        unterminated,
    output logic        last
);
    import sdt_pkg::*;

    localparam int CNT_W = $clog2(KEYWORD_BYTES + 1);
    localparam int IDX_W = $clog2(KEYWORD_BYTES);
    localparam int OW    = OFFSET_BITS;

    mode_t                     mode_reg, mode_next;
    logic [7:0]                quote_reg, quote_next;
    logic [OW-1:0]             offset_reg, offset_next;
    logic [OW-1:0]             start_reg, start_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      overlong_reg, overlong_next;
    logic [KEYWORD_BYTES*8-1:0] bytes_reg, bytes_next;

    logic          accept;
    logic [OW-1:0] offset_inc;
    logic [IDX_W-1:0] wr_idx;
    logic [5:0]    word_kind;
    logic          use_idle, do_append, do_end, end_unterm;
    logic          word_v, main_v;
    token_t        tok_word, tok_main, push0;
    logic [1:0]    push_cnt;
    logic          fifo_room;
    token_t        out_tok;

    function automatic logic [FIELD_W-1:0] clamp16(input logic [OW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    assign accept     = in_valid && in_ready;
    assign in_ready   = fifo_room;
    assign offset_inc = (offset_reg == '1) ? offset_reg : OW'(offset_reg + 1'b1);
    assign wr_idx     = count_reg[IDX_W-1:0];

    // keyword lookup on the word collected so far
    sdt_kw_match #(
        .KEYWORD_BYTES (KEYWORD_BYTES),
        .CNT_W         (CNT_W)
    ) u_kw_match (
        .word_bytes    (bytes_reg),
        .word_count    (count_reg),
        .word_overlong (overlong_reg),
        .kind          (word_kind)
    );

    // flushed word token
    always_comb
    begin
        tok_word.kind         = word_kind;
        tok_word.start        = clamp16(start_reg);
        tok_word.length       = clamp16(OW'(offset_reg - start_reg));
        tok_word.unterminated = 1'b0;
        tok_word.last         = 1'b0;
    end

    // scanner next state and token generation for one byte
    always_comb
    begin
        mode_next     = mode_reg;
        quote_next    = quote_reg;
        offset_next   = (text_byte != CH_NUL) ? offset_inc : offset_reg;
        start_next    = start_reg;
        count_next    = count_reg;
        overlong_next = overlong_reg;
        bytes_next    = bytes_reg;
        use_idle      = 1'b0;
        do_append     = 1'b0;
        do_end        = 1'b0;
        end_unterm    = 1'b0;
        word_v        = 1'b0;
        main_v        = 1'b0;
        tok_main      = '{kind: KIND_ID, start: clamp16(offset_reg), length: 16'd1,
                          unterminated: 1'b0, last: 1'b0};

        unique case (mode_reg)
            MODE_WORD:
            begin
                if ((text_byte == CH_NUL) || ends_word(text_byte))
                begin
                    word_v    = 1'b1;
                    mode_next = MODE_IDLE;
                    use_idle  = 1'b1;
                end
                else
                begin
                    do_append = 1'b1;
                end
            end
            MODE_QUOTE, MODE_ESC:
            begin
                if (text_byte == CH_NUL)
                begin
                    do_end     = 1'b1;
                    end_unterm = 1'b1;
                end
                else if (mode_reg == MODE_ESC)
                begin
                    mode_next = MODE_QUOTE;
                end
                else if (text_byte == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else if (text_byte == quote_reg)
                begin
                    main_v          = 1'b1;
                    tok_main.kind   = KIND_ID;
                    tok_main.start  = clamp16(start_reg);
                    tok_main.length = clamp16(OW'(offset_reg - start_reg));
                    mode_next       = MODE_IDLE;
                    quote_next      = CH_NUL;
                end
            end
            MODE_IDLE:
            begin
                use_idle = 1'b1;
            end
        endcase

        // byte seen between tokens
        if (use_idle)
        begin
            unique case (text_byte) inside
                CH_NUL:
                begin
                    do_end = 1'b1;
                end
                CH_DOT:
                begin
                    main_v        = 1'b1;
                    tok_main.kind = KIND_DOT;
                end
                CH_COMMA:
                begin
                    main_v        = 1'b1;
                    tok_main.kind = KIND_COMMA;
                end
                CH_LPAREN:
                begin
                    main_v        = 1'b1;
                    tok_main.kind = KIND_LP;
                end
                CH_RPAREN:
                begin
                    main_v        = 1'b1;
                    tok_main.kind = KIND_RP;
                end
                CH_EQUALS:
                begin
                    main_v        = 1'b1;
                    tok_main.kind = KIND_EQ;
                end
                CH_BQUOTE, CH_SQUOTE, CH_DQUOTE:
                begin
                    mode_next  = MODE_QUOTE;
                    quote_next = text_byte;
                    start_next = offset_inc;
                end
                default:
                begin
                    if (!is_space(text_byte))
                    begin
                        mode_next       = MODE_WORD;
                        start_next      = offset_reg;
                        count_next      = CNT_W'(1);
                        overlong_next   = 1'b0;
                        bytes_next[7:0] = to_upper(text_byte);
                    end
                end
            endcase
        end

        // word byte collection, extra bytes only mark the word overlong
        if (do_append)
        begin
            if (count_reg < CNT_W'(KEYWORD_BYTES))
            begin
                bytes_next[8*wr_idx +: 8] = to_upper(text_byte);
                count_next = CNT_W'(count_reg + 1'b1);
            end
            else
            begin
                overlong_next = 1'b1;
            end
        end

        // end of statement returns to the reset state
        if (do_end)
        begin
            main_v                = 1'b1;
            tok_main.kind         = KIND_END;
            tok_main.start        = clamp16(offset_reg);
            tok_main.length       = 16'd0;
            tok_main.unterminated = end_unterm;
            tok_main.last         = 1'b1;
            mode_next             = MODE_IDLE;
            quote_next            = CH_NUL;
            offset_next           = '0;
            start_next            = '0;
            count_next            = '0;
            overlong_next         = 1'b0;
        end
    end

    // tokens into the queue, flushed word first
    assign push_cnt = accept ? (2'(word_v) + 2'(main_v)) : 2'd0;
    assign push0    = word_v ? tok_word : tok_main;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            quote_reg    <= CH_NUL;
            offset_reg   <= '0;
            start_reg    <= '0;
            count_reg    <= '0;
            overlong_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            quote_reg    <= quote_next;
            offset_reg   <= offset_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
            overlong_reg <= overlong_next;
        end
    end

    // word bytes, read only below the fill count
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bytes_reg <= bytes_next;
        end
    end

    // output token queue
    sdt_tok_fifo #(
        .DEPTH     (FIFO_DEPTH)
    ) u_tok_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (push0),
        .push1     (tok_main),
        .room      (fifo_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_tok   (out_tok)
    );

    assign token_kind   = out_tok.kind;
    assign token_start  = out_tok.start;
    assign token_length = out_tok.length;
    assign unterminated = out_tok.unterminated;
    assign last         = out_tok.last;

    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> ((token_kind == KIND_END) && (token_length == 16'd0)))
        else $error("end token with wrong kind or length");

    a_unterm_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && unterminated) |-> last)
        else $error("unterminated flag outside end token");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (text_byte == CH_NUL)) |=> ((offset_reg == '0) && (mode_reg == MODE_IDLE)))
        else $error("scanner state not cleared after end of statement");

    a_word_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_WORD) |-> (count_reg != '0))
        else $error("word mode with no collected bytes");

endmodule
